// ===== sv/sorq_pkg.sv =====
// Shared types and constants for the size-ordered request queue.
// No dependencies; the queue and its checker import this package.
package sorq_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W    = 31;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_HANDLE_BITS = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_WAIT,
        S_ENQ_PUT,
        S_DEQ_WAIT,
        S_EMIT
    } t_state;

endpackage

// ===== sv/sorq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing; width and depth come from parameters.
module sorq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/size_ordered_request_queue.sv =====
// Size-ordered request queue: a circular buffer in one RAM, kept sorted smallest first.
// Dequeue: the result comes from a copy of the head; the RAM is read only to fetch the new head.
// Enqueue: entries larger than the new one move up one slot, scanning back from the tail; no scan
// into an empty or a full queue. The single RAM port pair moves one entry per cycle.
// One item is in work at a time; the next is taken the cycle after the result enters the
// output register. Synchronous active-low reset empties the queue; the RAM is not cleared.
module size_ordered_request_queue
    import sorq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Request channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_req_type,
    input  logic [HANDLE_BITS-1:0] i_item_handle,
    input  logic [KEY_W-1:0]       i_file_size,
    // Result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [KEY_W-1:0]       o_out_size,
    output logic [OCC_W-1:0]       o_occupancy,
    output logic                   o_now_empty
);

    // Address width for the RAM and a count wide enough to hold QUEUE_DEPTH itself.
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = KEY_W + HANDLE_BITS;

    // Wrapping pointer steps; the depth need not be a power of two.
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
        return (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(QUEUE_DEPTH - 1) : a - AW'(1);
    endfunction

    // Control state
    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;     // physical address of the smallest entry
    logic [AW-1:0] r_tail, n_tail;     // first free slot behind the largest entry
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_hole, n_hole;     // slot opened up during the insertion scan
    logic [AW-1:0] r_raddr, n_raddr;   // address of the read in flight
    logic [CW-1:0] r_left, n_left;     // entries still ahead of the hole
    logic          r_deq_ok, n_deq_ok;
    t_status       r_status, n_status;
    logic          r_out_valid, n_out_valid;

    // Payload state
    logic [KEY_W-1:0]       r_key, n_key;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic [KEY_W-1:0]       r_head_key, n_head_key;       // copy of the head entry
    logic [HANDLE_BITS-1:0] r_head_handle, n_head_handle;
    logic [KEY_W-1:0]       r_res_key, n_res_key;         // entry removed by a dequeue
    logic [HANDLE_BITS-1:0] r_res_handle, n_res_handle;
    logic [STATUS_W-1:0]    r_out_status, n_out_status;
    logic [HANDLE_BITS-1:0] r_out_handle, n_out_handle;
    logic [KEY_W-1:0]       r_out_size, n_out_size;
    logic [OCC_W-1:0]       r_out_occ, n_out_occ;
    logic                   r_out_empty, n_out_empty;

    // RAM port signals
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;

    sorq_ram #(
        .WIDTH(DW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign rd_key    = mem_rdata[DW-1 -: KEY_W];
    assign rd_handle = mem_rdata[HANDLE_BITS-1:0];

    // The block takes a new item only between operations.
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_hole      <= '0;
            r_raddr     <= '0;
            r_left      <= '0;
            r_deq_ok    <= 1'b0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_hole      <= n_hole;
            r_raddr     <= n_raddr;
            r_left      <= n_left;
            r_deq_ok    <= n_deq_ok;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_handle      <= n_handle;
        r_head_key    <= n_head_key;
        r_head_handle <= n_head_handle;
        r_res_key     <= n_res_key;
        r_res_handle  <= n_res_handle;
        r_out_status  <= n_out_status;
        r_out_handle  <= n_out_handle;
        r_out_size    <= n_out_size;
        r_out_occ     <= n_out_occ;
        r_out_empty   <= n_out_empty;
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_hole        = r_hole;
        n_raddr       = r_raddr;
        n_left        = r_left;
        n_deq_ok      = r_deq_ok;
        n_status      = r_status;
        n_out_valid   = r_out_valid;
        n_key         = r_key;
        n_handle      = r_handle;
        n_head_key    = r_head_key;
        n_head_handle = r_head_handle;
        n_res_key     = r_res_key;
        n_res_handle  = r_res_handle;
        n_out_status  = r_out_status;
        n_out_handle  = r_out_handle;
        n_out_size    = r_out_size;
        n_out_occ     = r_out_occ;
        n_out_empty   = r_out_empty;

        mem_we    = 1'b0;
        mem_waddr = r_hole;
        mem_wdata = {r_key, r_handle};
        mem_raddr = r_raddr;

        // The result register empties when the consumer takes the item.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = i_file_size;
                    n_handle = i_item_handle;
                    n_deq_ok = 1'b0;
                    if (t_req'(i_req_type) == REQ_ENQ) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            // Queue full: refuse, report the current head.
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else if (r_count == '0) begin
                            // Empty queue: the new entry becomes the head at once.
                            mem_we        = 1'b1;
                            mem_waddr     = r_tail;
                            mem_wdata     = {i_file_size, i_item_handle};
                            n_head_key    = i_file_size;
                            n_head_handle = i_item_handle;
                            n_tail        = ptr_inc(r_tail);
                            n_count       = r_count + CW'(1);
                            n_status      = ST_OK;
                            n_state       = S_EMIT;
                        end else begin
                            // Scan backwards from the tail, moving larger entries up one slot.
                            mem_raddr = ptr_dec(r_tail);
                            n_raddr   = ptr_dec(r_tail);
                            n_hole    = r_tail;
                            n_left    = r_count;
                            n_status  = ST_OK;
                            n_state   = S_ENQ_WAIT;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_EMIT;
                        end else begin
                            // The head copy is the answer; the new head is read back if any remain.
                            n_res_key    = r_head_key;
                            n_res_handle = r_head_handle;
                            n_deq_ok     = 1'b1;
                            n_head       = ptr_inc(r_head);
                            n_count      = r_count - CW'(1);
                            n_status     = ST_OK;
                            if (r_count != CW'(1)) begin
                                mem_raddr = ptr_inc(r_head);
                                n_state   = S_DEQ_WAIT;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                    end
                end
            end

            S_ENQ_WAIT: begin
                if (rd_key > r_key) begin
                    // Strictly larger: move it into the hole, the hole moves down.
                    mem_we    = 1'b1;
                    mem_waddr = r_hole;
                    mem_wdata = mem_rdata;
                    n_hole    = r_raddr;
                    n_left    = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_ENQ_PUT;
                    end else begin
                        mem_raddr = ptr_dec(r_raddr);
                        n_raddr   = ptr_dec(r_raddr);
                    end
                end else begin
                    // Not larger: the new entry goes right behind it, so the head is unchanged.
                    mem_we    = 1'b1;
                    mem_waddr = r_hole;
                    mem_wdata = {r_key, r_handle};
                    n_tail    = ptr_inc(r_tail);
                    n_count   = r_count + CW'(1);
                    n_state   = S_EMIT;
                end
            end

            S_ENQ_PUT: begin
                // Every entry was larger: the new one becomes the head.
                mem_we        = 1'b1;
                mem_waddr     = r_hole;
                mem_wdata     = {r_key, r_handle};
                n_head_key    = r_key;
                n_head_handle = r_handle;
                n_tail        = ptr_inc(r_tail);
                n_count       = r_count + CW'(1);
                n_state       = S_EMIT;
            end

            S_DEQ_WAIT: begin
                n_head_key    = rd_key;
                n_head_handle = rd_handle;
                n_state       = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_occ    = OCC_W'(r_count);
                    n_out_empty  = (r_count == '0);
                    if (r_deq_ok) begin
                        n_out_handle = r_res_handle;
                        n_out_size   = r_res_key;
                    end else if (r_count != '0) begin
                        n_out_handle = r_head_handle;
                        n_out_size   = r_head_key;
                    end else begin
                        n_out_handle = '0;
                        n_out_size   = '0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_out_handle = r_out_handle;
    assign o_out_size   = r_out_size;
    assign o_occupancy  = r_out_occ;
    assign o_now_empty  = r_out_empty;

endmodule

// ===== sv/sorq_checker.sv =====
// Port-level checks for the size-ordered request queue, bound to the top level.
// Depends on sorq_pkg for the status codes and field widths.
module sorq_checker
    import sorq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   i_req_type,
    input logic [HANDLE_BITS-1:0] i_item_handle,
    input logic [KEY_W-1:0]       i_file_size,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [STATUS_W-1:0]    o_status,
    input logic [HANDLE_BITS-1:0] o_out_handle,
    input logic [KEY_W-1:0]       o_out_size,
    input logic [OCC_W-1:0]       o_occupancy,
    input logic                   o_now_empty
);

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_out_handle) && $stable(o_out_size) && $stable(o_occupancy))
        else $error("result item changed while stalled");

    // Once an item is taken the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken straight after the first");

    // The empty flag agrees with the occupancy.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_now_empty == (o_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    // A refused dequeue reports an empty queue and zero payload.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
            o_out_handle == '0 && o_out_size == '0 && o_occupancy == '0)
        else $error("refused dequeue with non-zero fields");

    // A refused enqueue only happens with the queue at capacity.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("refused enqueue below capacity");

endmodule

bind size_ordered_request_queue sorq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
) u_sorq_checker (.*);
